/* rtl/fts_pkg.sv */
// shared constants, types and command/status structs of the frame time smoother
`timescale 1ns / 1ps
`default_nettype none
package fts_pkg;

    localparam int WINDOW_DEPTH = 16;

    localparam int DUR_W  = 32;
    localparam int TIME_W = 64;
    localparam int POS_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = DUR_W + $clog2(WINDOW_DEPTH);
    localparam int CNT_W  = $clog2(SUM_W + 1);

    localparam logic [DUR_W-1:0] RESET_DURATION_US  = DUR_W'(30000);
    localparam logic [DUR_W-1:0] RESET_THRESHOLD_US = DUR_W'(200000);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_UPDATE = 5'b00010,
        ST_START  = 5'b00100,
        ST_DIV    = 5'b01000,
        ST_FINISH = 5'b10000
    } fts_state_t;

    typedef struct packed {
        logic load_in;
        logic update_ring;
        logic div_start;
        logic finish;
    } fts_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic out_free;
    } fts_sts_t;

endpackage
`default_nettype wire

/* rtl/fts_div.sv */
// restoring serial divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module fts_div
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [fts_pkg::SUM_W-1:0]  dividend,
    input  wire logic [fts_pkg::FILL_W-1:0] divisor,
    output logic                            busy,
    output logic [fts_pkg::SUM_W-1:0]       quotient
);

    logic                        busy_reg, busy_next;
    logic [fts_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [fts_pkg::SUM_W-1:0]   work_reg, work_next;
    logic [fts_pkg::FILL_W-1:0]  rem_reg, rem_next;
    logic [fts_pkg::FILL_W-1:0]  dvs_reg, dvs_next;
    logic [fts_pkg::FILL_W:0]    rem_shift;
    logic [fts_pkg::FILL_W+1:0]  trial;

    assign rem_shift = {rem_reg, work_reg[fts_pkg::SUM_W-1]};
    assign trial     = {1'b0, rem_shift} - {2'b00, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = fts_pkg::CNT_W'(fts_pkg::SUM_W);
            work_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // trial subtract: borrow clear means the quotient bit is one
            if (!trial[fts_pkg::FILL_W+1])
            begin
                rem_next  = trial[fts_pkg::FILL_W-1:0];
                work_next = {work_reg[fts_pkg::SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_shift[fts_pkg::FILL_W-1:0];
                work_next = {work_reg[fts_pkg::SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == fts_pkg::CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = work_reg;

endmodule
`default_nettype wire

/* rtl/fts_ctrl.sv */
// sequencing state machine of the frame time smoother
`timescale 1ns / 1ps
`default_nettype none
module fts_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire fts_pkg::fts_sts_t sts,
    output fts_pkg::fts_cmd_t      cmd
);

    fts_pkg::fts_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            fts_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = fts_pkg::ST_UPDATE;
                end
            end
            fts_pkg::ST_UPDATE:
            begin
                cmd.update_ring = 1'b1;
                state_next      = fts_pkg::ST_START;
            end
            fts_pkg::ST_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = fts_pkg::ST_DIV;
            end
            fts_pkg::ST_DIV:
            begin
                if (!sts.div_busy)
                begin
                    state_next = fts_pkg::ST_FINISH;
                end
            end
            fts_pkg::ST_FINISH:
            begin
                // wait until the output register can take the result
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = fts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fts_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fts_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/fts_dp.sv */
// datapath: duration ring, running sum, divider, time accumulator and output register
`timescale 1ns / 1ps
`default_nettype none
module fts_dp
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_write_en,
    input  wire logic [fts_pkg::DUR_W-1:0] cfg_write_data,
    input  wire logic [fts_pkg::DUR_W-1:0] delta_us,
    input  wire fts_pkg::fts_cmd_t         cmd,
    output fts_pkg::fts_sts_t              sts,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [fts_pkg::DUR_W-1:0]      predicted_duration_us,
    output logic [fts_pkg::TIME_W-1:0]     current_time_us,
    output logic [fts_pkg::DUR_W-1:0]      frame_time_us
);

    logic [fts_pkg::DUR_W-1:0]  ring_mem [fts_pkg::WINDOW_DEPTH];
    logic [fts_pkg::DUR_W-1:0]  rd_data_reg;

    logic [fts_pkg::DUR_W-1:0]  thr_reg;
    logic [fts_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [fts_pkg::FILL_W-1:0] fill_reg;
    logic [fts_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic [fts_pkg::TIME_W-1:0] acc_reg, acc_next;
    logic [fts_pkg::DUR_W-1:0]  held_reg, held_next;
    logic [fts_pkg::DUR_W-1:0]  latest_reg;
    logic                       entry0_written_reg;
    logic [fts_pkg::DUR_W-1:0]  dur_reg;
    logic [fts_pkg::DUR_W-1:0]  old_dur;
    logic                       full;

    logic                       out_valid_reg;
    logic [fts_pkg::DUR_W-1:0]  out_pred_reg;
    logic [fts_pkg::TIME_W-1:0] out_time_reg;
    logic [fts_pkg::DUR_W-1:0]  out_frame_reg;

    logic                       div_busy;
    logic [fts_pkg::SUM_W-1:0]  quotient;
    logic [fts_pkg::DUR_W-1:0]  mean;

    assign pos_next = (pos_reg == fts_pkg::POS_W'(fts_pkg::WINDOW_DEPTH - 1))
                      ? '0 : pos_reg + 1'b1;
    assign full     = (fill_reg == fts_pkg::FILL_W'(fts_pkg::WINDOW_DEPTH));

    // entry zero holds the reset duration until first overwritten
    assign old_dur  = ((pos_reg == '0) && !entry0_written_reg)
                      ? fts_pkg::RESET_DURATION_US : rd_data_reg;

    assign sum_next = full
                      ? sum_reg - fts_pkg::SUM_W'(old_dur) + fts_pkg::SUM_W'(dur_reg)
                      : sum_reg + fts_pkg::SUM_W'(dur_reg);

    assign mean      = quotient[fts_pkg::DUR_W-1:0];
    assign acc_next  = acc_reg + fts_pkg::TIME_W'(mean);
    assign held_next = (mean != '0) ? mean : held_reg;

    // ring memory: read of the slot to be replaced, write of the new duration
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            rd_data_reg <= ring_mem[pos_next];
        end
        if (cmd.update_ring)
        begin
            ring_mem[pos_reg] <= dur_reg;
        end
    end

    // outliers take the newest stored duration
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            dur_reg <= (delta_us > thr_reg) ? latest_reg : delta_us;
        end
        if (cmd.finish)
        begin
            out_pred_reg  <= mean;
            out_time_reg  <= acc_next;
            out_frame_reg <= held_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg            <= fts_pkg::RESET_THRESHOLD_US;
            pos_reg            <= '0;
            fill_reg           <= fts_pkg::FILL_W'(1);
            sum_reg            <= fts_pkg::SUM_W'(fts_pkg::RESET_DURATION_US);
            acc_reg            <= '0;
            held_reg           <= fts_pkg::RESET_DURATION_US;
            latest_reg         <= fts_pkg::RESET_DURATION_US;
            entry0_written_reg <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                thr_reg <= cfg_write_data;
            end
            if (cmd.load_in)
            begin
                pos_reg <= pos_next;
            end
            if (cmd.update_ring)
            begin
                sum_reg    <= sum_next;
                latest_reg <= dur_reg;
                if (!full)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
                if (pos_reg == '0)
                begin
                    entry0_written_reg <= 1'b1;
                end
            end
            if (cmd.finish)
            begin
                acc_reg       <= acc_next;
                held_reg      <= held_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    fts_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (fill_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign sts.div_busy = div_busy;
    assign sts.out_free = !out_valid_reg || !out_stall;

    assign out_valid             = out_valid_reg;
    assign predicted_duration_us = out_pred_reg;
    assign current_time_us       = out_time_reg;
    assign frame_time_us         = out_frame_reg;

endmodule
`default_nettype wire

/* rtl/frame_time_smoother_top.sv */
// top level of the frame time smoother
`timescale 1ns / 1ps
`default_nettype none
// frame time smoother: takes one measured frame duration (delta_us, unsigned
// microseconds) per request and returns the truncated mean of the last
// WINDOW_DEPTH stored durations, the 64-bit running time (wraps) and the last
// non-zero mean. a duration above the outlier threshold is replaced by the
// newest stored duration. after reset the window holds one entry of 30000 us
// and the threshold is 200000 us. the serial divider produces one quotient bit per
// cycle; requests are handled one at a time, and a new one is taken while the
// previous result still waits in the output register
module frame_time_smoother_top
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // threshold register write
    input  wire logic                       cfg_write_en,
    input  wire logic [fts_pkg::DUR_W-1:0]  cfg_write_data,
    // request side
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [fts_pkg::DUR_W-1:0]  delta_us,
    // result side
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [fts_pkg::DUR_W-1:0]       predicted_duration_us,
    output logic [fts_pkg::TIME_W-1:0]      current_time_us,
    output logic [fts_pkg::DUR_W-1:0]       frame_time_us
);

    fts_pkg::fts_cmd_t cmd;
    fts_pkg::fts_sts_t sts;

    // sequencer: accept, ring update, divide, hand over
    fts_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // ring, running sum, divider and output register
    fts_dp u_dp
    (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cfg_write_en          (cfg_write_en),
        .cfg_write_data        (cfg_write_data),
        .delta_us              (delta_us),
        .cmd                   (cmd),
        .sts                   (sts),
        .out_valid             (out_valid),
        .out_stall             (out_stall),
        .predicted_duration_us (predicted_duration_us),
        .current_time_us       (current_time_us),
        .frame_time_us         (frame_time_us)
    );

endmodule
`default_nettype wire

/* sim/testbench.sv */
// self-checking testbench for the frame time smoother, with its own running-mean predictor
`timescale 1ns / 1ps

module testbench;
    import fts_pkg::*;

    // one smoothed frame as the block reports it
    typedef struct {
        logic [DUR_W-1:0]  mean_us;
        logic [TIME_W-1:0] clock_us;
        logic [DUR_W-1:0]  held_us;
    } frame_result_t;

    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 220;
    localparam int ZERO_RUN        = WINDOW_DEPTH + 1;

    logic              clk            = 1'b0;
    logic              rst_n          = 1'b0;
    logic              cfg_write_en   = 1'b0;
    logic [DUR_W-1:0]  cfg_write_data = '0;
    logic              in_valid       = 1'b0;
    logic              in_stall;
    logic [DUR_W-1:0]  delta_us       = '0;
    logic              out_valid;
    logic              out_stall      = 1'b0;
    logic [DUR_W-1:0]  predicted_duration_us;
    logic [TIME_W-1:0] current_time_us;
    logic [DUR_W-1:0]  frame_time_us;

    frame_time_smoother_top dut
    (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cfg_write_en          (cfg_write_en),
        .cfg_write_data        (cfg_write_data),
        .in_valid              (in_valid),
        .in_stall              (in_stall),
        .delta_us              (delta_us),
        .out_valid             (out_valid),
        .out_stall             (out_stall),
        .predicted_duration_us (predicted_duration_us),
        .current_time_us       (current_time_us),
        .frame_time_us         (frame_time_us)
    );

    always #5 clk = ~clk;

    // durations waiting to be sent, and smoothed frames still to come back
    logic [DUR_W-1:0] frame_deltas [$];
    frame_result_t    awaited_frames [$];

    // predictor state, kept in step with the accepted requests
    logic [DUR_W-1:0]  model_ring [WINDOW_DEPTH];
    int unsigned       model_pos;
    int unsigned       model_fill;
    logic [SUM_W-1:0]  model_sum;
    logic [TIME_W-1:0] model_clock;
    logic [DUR_W-1:0]  model_held;
    logic [DUR_W-1:0]  model_threshold;

    // idling control
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  send_gap      = 0;
    int  recv_gap      = 0;
    bit  calm          = 1'b0;
    bit  hold_results  = 1'b0;
    bit  req_taken     = 1'b0;
    int  accepted      = 0;
    int  mismatches    = 0;

    logic [DUR_W-1:0] phase_threshold [PHASES];
    int               phase_send_idle [PHASES];
    int               phase_recv_idle [PHASES];

    // one step of the moving average: outlier swap, ring update, mean, time
    function automatic frame_result_t smooth_frame(input logic [DUR_W-1:0] delta);
        logic [DUR_W-1:0] stored;
        int unsigned      next_pos;
        frame_result_t    res;
        // an outlier repeats the newest stored duration
        stored   = (delta > model_threshold) ? model_ring[model_pos] : delta;
        next_pos = (model_pos + 1) % WINDOW_DEPTH;
        if (model_fill < WINDOW_DEPTH)
            model_fill++;
        else
            model_sum = model_sum - SUM_W'(model_ring[next_pos]);
        model_ring[next_pos] = stored;
        model_sum   = model_sum + SUM_W'(stored);
        model_pos   = next_pos;
        res.mean_us = DUR_W'(model_sum / SUM_W'(model_fill));
        model_clock = model_clock + TIME_W'(res.mean_us);
        if (res.mean_us != '0)
            model_held = res.mean_us;
        res.clock_us = model_clock;
        res.held_us  = model_held;
        return res;
    endfunction

    task automatic wait_until_idle();
        while (frame_deltas.size() != 0 || in_valid || awaited_frames.size() != 0)
            @(posedge clk);
    endtask

    // threshold writes only happen with nothing in flight
    task automatic write_threshold(input logic [DUR_W-1:0] value);
        wait_until_idle();
        @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(negedge clk);
        cfg_write_en    <= 1'b0;
        model_threshold  = value;
        @(posedge clk);
    endtask

    // request driver: new values at the falling edge, a held request stays put
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || req_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (frame_deltas.size() != 0 && !calm &&
                     $urandom_range(99) < send_idle_pct)
            begin
                // idle this cycle and start a random gap of further idle cycles
                send_gap <= $urandom_range(8);
                in_valid <= 1'b0;
            end
            else if (frame_deltas.size() != 0)
            begin
                in_valid <= 1'b1;
                delta_us <= frame_deltas.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // result side stall: random bursts plus the long hold-off
    always @(negedge clk)
    begin
        if (recv_gap > 0)
        begin
            recv_gap  <= recv_gap - 1;
            out_stall <= 1'b1;
        end
        else if (!calm && $urandom_range(99) < recv_idle_pct)
        begin
            recv_gap  <= $urandom_range(8);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= hold_results;
        end
    end

    // monitor: checks each returned frame, then records an accepted request
    always @(posedge clk)
    begin : monitor
        frame_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_frames.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result mean %0d time %0d frame %0d", $realtime,
                             predicted_duration_us, current_time_us, frame_time_us);
            end
            else
            begin
                want = awaited_frames.pop_front();
                if (predicted_duration_us !== want.mean_us ||
                    current_time_us !== want.clock_us ||
                    frame_time_us !== want.held_us)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: mismatch mean %0d/%0d time %0d/%0d frame %0d/%0d (exp/got)",
                                 $realtime, want.mean_us, predicted_duration_us,
                                 want.clock_us, current_time_us,
                                 want.held_us, frame_time_us);
                end
            end
        end
        req_taken = rst_n && in_valid && !in_stall;
        if (req_taken)
        begin
            awaited_frames.push_back(smooth_frame(delta_us));
            accepted++;
        end
    end

    // long hold-off on the result side so the block backs up into in_stall
    initial
    begin
        while (accepted < 400)
            @(posedge clk);
        hold_results = 1'b1;
        repeat (300) @(posedge clk);
        hold_results = 1'b0;
    end

    initial
    begin
        #5ms;
        $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        int               n;
        logic [DUR_W-1:0] d;

        // predictor after reset: one entry of 30000 us in the window
        foreach (model_ring[i])
            model_ring[i] = '0;
        model_ring[0]   = RESET_DURATION_US;
        model_pos       = 0;
        model_fill      = 1;
        model_sum       = SUM_W'(RESET_DURATION_US);
        model_clock     = '0;
        model_held      = RESET_DURATION_US;
        model_threshold = RESET_THRESHOLD_US;

        // extremes first, then random thresholds with one more all-ones, reset value last
        phase_threshold = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, $urandom_range(300000, 1000),
                            32'hFFFF_FFFF, $urandom, RESET_THRESHOLD_US};
        phase_send_idle = '{15, 0, 30, 10, 40, 20, 0};
        phase_recv_idle = '{20, 10, 0, 30, 15, 40, 0};

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part under the reset threshold
        send_idle_pct = 10;
        recv_idle_pct = 10;
        frame_deltas.push_back(32'd0);
        frame_deltas.push_back(32'hFFFF_FFFF);   // outlier, repeats the zero just stored
        frame_deltas.push_back(32'd200000);      // equal to the threshold, kept
        frame_deltas.push_back(32'd200001);      // just above, swapped
        frame_deltas.push_back(32'd1);
        frame_deltas.push_back(32'h8000_0000);
        // a full window of zeros gives a zero mean, frame time must hold
        repeat (WINDOW_DEPTH) frame_deltas.push_back(32'd0);
        frame_deltas.push_back(32'd100000);
        frame_deltas.push_back(32'd33333);

        for (int p = 0; p < PHASES; p++)
        begin
            write_threshold(phase_threshold[p]);
            send_idle_pct = phase_send_idle[p];
            recv_idle_pct = phase_recv_idle[p];
            calm          = (p == PHASES - 1);
            n = 0;
            while (n < ITEMS_PER_PHASE)
            begin
                if ($urandom_range(39) == 0)
                begin
                    // run of zeros long enough to flush the window
                    repeat (ZERO_RUN) frame_deltas.push_back('0);
                    n += ZERO_RUN;
                end
                else
                begin
                    case ($urandom_range(9))
                        0:       d = '0;
                        1:       d = 32'hFFFF_FFFF;
                        2, 3:    d = $urandom;
                        4, 5:    d = model_threshold + DUR_W'($urandom_range(4)) - 32'd2;
                        6, 7:    d = $urandom_range(100000);
                        8:       d = 32'd1 << $urandom_range(31);
                        default: d = 32'hFFFF_FFFF - $urandom_range(1000);
                    endcase
                    frame_deltas.push_back(d);
                    n++;
                end
            end
        end

        wait_until_idle();
        // allow for any stray result after the last expected one
        repeat (60) @(posedge clk);
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
